// ----- hdl/rcfrt_pkg.sv -----
// Shared types and constants for the radio-control frame receiver with telemetry reply.
`default_nettype none
package rcfrt_pkg;

	localparam int STORE_DEPTH = 32;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
	localparam int CMP_W       = (FILL_W > 9) ? FILL_W : 9;

	localparam logic [7:0] END_MARK      = 8'h7E;
	localparam logic [7:0] TYPE_CHANNELS = 8'h04;
	localparam logic [7:0] TYPE_POLL     = 8'h1B;
	localparam logic [7:0] REPLY_LEN     = 8'h08;
	localparam logic [7:0] REPLY_CODE    = 8'h10;
	localparam logic [7:0] CHECK_BASE    = 8'hFF;

	localparam logic ACTION_LINE  = 1'b0;
	localparam logic ACTION_QUEUE = 1'b1;
	localparam logic KIND_CHANNEL = 1'b0;
	localparam logic KIND_REPLY   = 1'b1;

	localparam int CH_W        = 11;
	localparam int ACC_W       = 18;
	localparam int BITS_W      = 5;
	localparam int CH_FIRST    = 2;
	localparam int PAYLOAD_LEN = 22;
	localparam logic [3:0] CH_LAST = 4'd15;

	// reply byte positions
	localparam logic [3:0] REP_OPEN   = 4'd0;
	localparam logic [3:0] REP_LEN    = 4'd1;
	localparam logic [3:0] REP_CODE   = 4'd2;
	localparam logic [3:0] REP_ID_LO  = 4'd3;
	localparam logic [3:0] REP_ID_HI  = 4'd4;
	localparam logic [3:0] REP_VAL_0  = 4'd5;
	localparam logic [3:0] REP_VAL_1  = 4'd6;
	localparam logic [3:0] REP_VAL_2  = 4'd7;
	localparam logic [3:0] REP_VAL_3  = 4'd8;
	localparam logic [3:0] REP_CHECK  = 4'd9;
	localparam logic [3:0] REP_CLOSE  = 4'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CH_READ,
		ST_CH_WAIT,
		ST_CH_EMIT,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic queue_tel;
		logic store_byte;
		logic clr_fill;
		logic start_ch;
		logic start_rep;
		logic rd_issue;
		logic rd_take;
		logic ch_emit;
		logic rep_emit;
		logic clr_pending;
	} cmd_t;

	typedef struct packed {
		logic is_end;
		logic frame_ch;
		logic frame_poll;
		logic full;
		logic out_free;
		logic acc_ge11;
		logic ch_last;
		logic rep_last;
	} sts_t;

endpackage
`default_nettype wire

// ----- hdl/rcfrt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rcfrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/rcfrt_ctrl.sv -----
// Controller state machine: byte handling, channel unpack sequence and reply sequence.
`default_nettype none
module rcfrt_ctrl
	import rcfrt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic action,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (action == ACTION_QUEUE) begin
						cmd.queue_tel = 1'b1;
					end else if (sts.is_end) begin
						cmd.clr_fill = 1'b1;
						if (sts.frame_ch) begin
							cmd.start_ch = 1'b1;
							state_d      = ST_CH_READ;
						end else if (sts.frame_poll) begin
							cmd.start_rep = 1'b1;
							state_d       = ST_REPLY;
						end
					end else if (sts.full) begin
						// drop the byte and restart the frame
						cmd.clr_fill = 1'b1;
					end else begin
						cmd.store_byte = 1'b1;
					end
				end
			end
			ST_CH_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_CH_WAIT;
			end
			ST_CH_WAIT: begin
				cmd.rd_take = 1'b1;
				state_d     = ST_CH_EMIT;
			end
			ST_CH_EMIT: begin
				if (!sts.acc_ge11) begin
					state_d = ST_CH_READ;
				end else if (sts.out_free) begin
					cmd.ch_emit = 1'b1;
					state_d     = sts.ch_last ? ST_IDLE : ST_CH_READ;
				end
			end
			ST_REPLY: begin
				if (sts.out_free) begin
					cmd.rep_emit = 1'b1;
					if (sts.rep_last) begin
						cmd.clr_pending = 1'b1;
						state_d         = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/rcfrt_dp.sv -----
// Datapath: frame store, header checks, bit unpacker, reply builder and output register.
`default_nettype none
module rcfrt_dp
	import rcfrt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [15:0] sensor_tag,
	input  wire logic [31:0] sensor_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [3:0]       channel_index,
	output logic [CH_W-1:0]  channel_value,
	output logic [7:0]       tx_byte,
	output logic             last
);

	logic [FILL_W-1:0]      fill_q;
	logic [STORE_DEPTH-1:0] vld_q;
	logic [7:0]             len_q, type_q;
	logic                   pend_q;
	logic [15:0]            pid_q;
	logic [31:0]            pval_q;

	logic [ADDR_W-1:0]      wr_addr, rd_addr;
	logic [7:0]             ram_data;
	logic                   vld_s1;
	logic [7:0]             rd_byte;

	logic [BITS_W-1:0]      rd_cnt_q;
	logic [ACC_W-1:0]       acc_q;
	logic [BITS_W-1:0]      bits_q;
	logic [3:0]             ch_q;

	logic [3:0]             rep_idx_q;
	logic [7:0]             sum_q;
	logic [7:0]             rep_byte;
	logic [8:0]             sum_raw;
	logic [7:0]             sum_fold;

	logic                   out_valid_q, kind_q, last_q;
	logic [3:0]             idx_q;
	logic [CH_W-1:0]        val_q;
	logic [7:0]             tx_q;

	logic [CMP_W-1:0]       len_ext, fill_ext;
	logic                   frame_ok;

	assign wr_addr = fill_q[ADDR_W-1:0];
	assign rd_addr = ADDR_W'(CH_FIRST) + ADDR_W'(rd_cnt_q);

	rcfrt_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.store_byte),
		.wr_addr (wr_addr),
		.wr_data (rx_byte),
		.rd_en   (cmd.rd_issue),
		.rd_addr (rd_addr),
		.rd_data (ram_data)
	);

	// never-written entries read as zero
	assign rd_byte = vld_s1 ? ram_data : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			vld_q  <= '0;
			pend_q <= 1'b0;
			pid_q  <= '0;
			pval_q <= '0;
		end else begin
			if (cmd.clr_fill) begin
				fill_q <= '0;
			end else if (cmd.store_byte) begin
				fill_q         <= fill_q + FILL_W'(1);
				vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.queue_tel && !pend_q) begin
				pend_q <= 1'b1;
				pid_q  <= sensor_tag;
				pval_q <= sensor_value;
			end else if (cmd.clr_pending) begin
				pend_q <= 1'b0;
			end
		end
	end

	// hold header copies of store positions 0 and 1
	always_ff @(posedge clk) begin
		if (cmd.store_byte && fill_q == FILL_W'(0)) begin
			len_q <= rx_byte;
		end
		if (cmd.store_byte && fill_q == FILL_W'(1)) begin
			type_q <= rx_byte;
		end
		if (cmd.rd_issue) begin
			vld_s1 <= vld_q[rd_addr];
		end
	end

	assign len_ext  = CMP_W'(len_q) + CMP_W'(1);
	assign fill_ext = CMP_W'(fill_q);
	assign frame_ok = (fill_q > FILL_W'(3)) && (len_ext <= fill_ext);

	// channel unpacker: append bytes LSB first, take 11 bits at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			bits_q   <= '0;
			ch_q     <= '0;
		end else if (cmd.start_ch) begin
			rd_cnt_q <= '0;
			bits_q   <= '0;
			ch_q     <= '0;
		end else begin
			if (cmd.rd_take) begin
				rd_cnt_q <= rd_cnt_q + BITS_W'(1);
				bits_q   <= bits_q + BITS_W'(8);
			end else if (cmd.ch_emit) begin
				bits_q <= bits_q - BITS_W'(CH_W);
				ch_q   <= ch_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_ch) begin
			acc_q <= '0;
		end else if (cmd.rd_take) begin
			acc_q <= acc_q | (ACC_W'(rd_byte) << bits_q);
		end else if (cmd.ch_emit) begin
			acc_q <= acc_q >> CH_W;
		end
	end

	// reply byte selection
	always_comb begin
		case (rep_idx_q)
			REP_OPEN:  rep_byte = END_MARK;
			REP_LEN:   rep_byte = REPLY_LEN;
			REP_CODE:  rep_byte = REPLY_CODE;
			REP_ID_LO: rep_byte = pid_q[7:0];
			REP_ID_HI: rep_byte = pid_q[15:8];
			REP_VAL_0: rep_byte = pval_q[7:0];
			REP_VAL_1: rep_byte = pval_q[15:8];
			REP_VAL_2: rep_byte = pval_q[23:16];
			REP_VAL_3: rep_byte = pval_q[31:24];
			REP_CHECK: rep_byte = CHECK_BASE - sum_q;
			REP_CLOSE: rep_byte = END_MARK;
			default:   rep_byte = END_MARK;
		endcase
	end

	// end-around carry sum, folded a byte at a time
	assign sum_raw  = {1'b0, sum_q} + {1'b0, rep_byte};
	assign sum_fold = sum_raw[8] ? (sum_raw[7:0] + 8'd1) : sum_raw[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_idx_q <= '0;
		end else if (cmd.start_rep) begin
			rep_idx_q <= '0;
		end else if (cmd.rep_emit) begin
			rep_idx_q <= rep_idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_rep) begin
			sum_q <= '0;
		end else if (cmd.rep_emit && rep_idx_q >= REP_LEN && rep_idx_q <= REP_VAL_3) begin
			sum_q <= sum_fold;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ch_emit || cmd.rep_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ch_emit) begin
			kind_q <= KIND_CHANNEL;
			idx_q  <= ch_q;
			val_q  <= acc_q[CH_W-1:0];
			tx_q   <= 8'h00;
			last_q <= (ch_q == CH_LAST);
		end else if (cmd.rep_emit) begin
			kind_q <= KIND_REPLY;
			idx_q  <= 4'd0;
			val_q  <= '0;
			tx_q   <= rep_byte;
			last_q <= (rep_idx_q == REP_CLOSE);
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign channel_index = idx_q;
	assign channel_value = val_q;
	assign tx_byte       = tx_q;
	assign last          = last_q;

	always_comb begin
		sts.is_end     = (rx_byte == END_MARK);
		sts.frame_ch   = frame_ok && (type_q == TYPE_CHANNELS);
		sts.frame_poll = frame_ok && (type_q == TYPE_POLL) && pend_q;
		sts.full       = (fill_q == FILL_W'(STORE_DEPTH));
		sts.out_free   = !out_valid_q || out_ready;
		sts.acc_ge11   = (bits_q >= BITS_W'(CH_W));
		sts.ch_last    = (ch_q == CH_LAST);
		sts.rep_last   = (rep_idx_q == REP_CLOSE);
	end

`ifndef NO_ASSERTIONS
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= BITS_W'(ACC_W))
		else $error("unpacker bit count beyond accumulator width");

	a_emit_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ch_emit |-> bits_q >= BITS_W'(CH_W))
		else $error("channel emitted with too few bits");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(cmd.ch_emit || cmd.rep_emit))
		else $error("output register overwritten while stalled");

	a_reply_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rep_emit && rep_idx_q == REP_CLOSE) |=> !pend_q)
		else $error("pending flag kept after reply");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(STORE_DEPTH))
		else $error("fill count beyond store depth");
`endif

endmodule
`default_nettype wire

// ----- hdl/rc_frame_receiver_telemetry.sv -----
// Radio-control frame receiver with channel unpack and one-slot telemetry reply.
// Each line byte or telemetry queue transaction is taken while the controller is idle. The byte
// 0x7E closes a frame: a channel frame (type 0x04) then occupies the block for 22 store reads,
// each through the read, wait and emit states, while the sixteen 11-bit channels leave as a
// run; a poll frame (type 0x1B) with a pending value gives an 11-byte reply, one byte a cycle
// while the output is not stalled. Input is held off during a run or reply. The single read
// port of the frame store and the one-entry output register pace the run; output stalls slow
// it. No reset sweep: per-entry valid bits make unwritten store positions read as zero.
`default_nettype none
module rc_frame_receiver_telemetry
	import rcfrt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [15:0] sensor_tag,
	input  wire logic [31:0] sensor_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [3:0]       channel_index,
	output logic [10:0]      channel_value,
	output logic [7:0]       tx_byte,
	output logic             last
);

	cmd_t cmd;
	sts_t sts;

	rcfrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.sts      (sts),
		.cmd      (cmd)
	);

	rcfrt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.rx_byte       (rx_byte),
		.sensor_tag    (sensor_tag),
		.sensor_value  (sensor_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.tx_byte       (tx_byte),
		.last          (last)
	);

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking bench for the radio-control frame receiver: directed frames, random traffic, then a receiver hold-off.
module testbench;
	import rcfrt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_LEN    = 400;
	localparam int PHASE_ITEMS = 60;

	typedef struct packed {
		logic        action;
		logic [7:0]  rx_byte;
		logic [15:0] sensor_tag;
		logic [31:0] sensor_value;
	} line_item_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  channel_index;
		logic [10:0] channel_value;
		logic [7:0]  tx_byte;
		logic        last;
	} out_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = ACTION_LINE;
	logic [7:0]  rx_byte = '0;
	logic [15:0] sensor_tag = '0;
	logic [31:0] sensor_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [3:0]  channel_index;
	logic [10:0] channel_value;
	logic [7:0]  tx_byte;
	logic        last;

	// stimulus and bookkeeping
	line_item_t  line_q[$];
	out_rec_t    outbound_q[$];
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	logic        hold_arm = 1'b0;
	logic        hold_used = 1'b0;
	int          hold_left = 0;
	int          errors = 0;
	int          queued = 0;
	int          accepted = 0;
	int          channel_runs = 0;
	int          replies = 0;
	int unsigned cycles = 0;

	// predictor state
	logic [7:0]  frame_bytes [STORE_DEPTH] = '{default: '0};
	int          fill_level = 0;
	logic        tel_pending = 1'b0;
	logic [15:0] tel_id = '0;
	logic [31:0] tel_value = '0;

	rc_frame_receiver_telemetry dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.rx_byte       (rx_byte),
		.sensor_tag    (sensor_tag),
		.sensor_value  (sensor_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.tx_byte       (tx_byte),
		.last          (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Work out the channel run or reply that one accepted transaction causes.
	task automatic digest_item(input line_item_t it);
		int unsigned bitpos;
		int unsigned base;
		int unsigned sum;
		logic [23:0] window;
		logic [7:0]  reply [11];
		out_rec_t    rec;
		if (it.action == ACTION_QUEUE) begin
			if (!tel_pending) begin
				tel_id = it.sensor_tag;
				tel_value = it.sensor_value;
				tel_pending = 1'b1;
			end
		end else if (it.rx_byte == END_MARK) begin
			if (fill_level > 3 && int'(frame_bytes[0]) + 1 <= fill_level) begin
				if (frame_bytes[1] == TYPE_CHANNELS) begin
					for (int c = 0; c < 16; c++) begin
						bitpos = c * CH_W;
						base = CH_FIRST + bitpos / 8;
						window = {frame_bytes[base + 2], frame_bytes[base + 1],
							frame_bytes[base]};
						rec.kind = KIND_CHANNEL;
						rec.channel_index = 4'(c);
						rec.channel_value = 11'(window >> (bitpos % 8));
						rec.tx_byte = '0;
						rec.last = (c == 15);
						outbound_q.push_back(rec);
					end
					channel_runs++;
				end else if (frame_bytes[1] == TYPE_POLL && tel_pending) begin
					reply[REP_OPEN]  = END_MARK;
					reply[REP_LEN]   = REPLY_LEN;
					reply[REP_CODE]  = REPLY_CODE;
					reply[REP_ID_LO] = tel_id[7:0];
					reply[REP_ID_HI] = tel_id[15:8];
					reply[REP_VAL_0] = tel_value[7:0];
					reply[REP_VAL_1] = tel_value[15:8];
					reply[REP_VAL_2] = tel_value[23:16];
					reply[REP_VAL_3] = tel_value[31:24];
					sum = 0;
					for (int i = REP_LEN; i <= REP_VAL_3; i++)
						sum += reply[i];
					// fold carries back into the low byte
					while (sum > 'hFF)
						sum = (sum & 'hFF) + (sum >> 8);
					reply[REP_CHECK] = CHECK_BASE - 8'(sum);
					reply[REP_CLOSE] = END_MARK;
					for (int i = 0; i < 11; i++) begin
						rec.kind = KIND_REPLY;
						rec.channel_index = '0;
						rec.channel_value = '0;
						rec.tx_byte = reply[i];
						rec.last = (i == REP_CLOSE);
						outbound_q.push_back(rec);
					end
					tel_pending = 1'b0;
					replies++;
				end
			end
			fill_level = 0;
		end else if (fill_level < STORE_DEPTH) begin
			frame_bytes[fill_level] = it.rx_byte;
			fill_level++;
		end else begin
			// store full: drop the byte and restart
			fill_level = 0;
		end
	endtask

	// Sender: hold each transaction until accepted, idle at random between them.
	always @(posedge clk or negedge arst_n) begin
		line_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (line_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = line_q.pop_front();
				in_valid <= 1'b1;
				action <= nxt.action;
				rx_byte <= nxt.rx_byte;
				sensor_tag <= nxt.sensor_tag;
				sensor_value <= nxt.sensor_value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off when armed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_arm && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: predict on input transactions, compare on output transactions.
	always @(posedge clk) begin
		out_rec_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				digest_item({action, rx_byte, sensor_tag, sensor_value});
				accepted++;
			end
			if (out_valid && out_ready) begin
				if (outbound_q.size() == 0) begin
					$error("result with nothing expected: kind %0d idx %0d val %0d tx %0h",
						kind, channel_index, channel_value, tx_byte);
					errors++;
				end else begin
					want = outbound_q.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						errors++;
					end
					if (channel_index !== want.channel_index) begin
						$error("channel_index: expected %0d, got %0d",
							want.channel_index, channel_index);
						errors++;
					end
					if (channel_value !== want.channel_value) begin
						$error("channel_value: expected %0d, got %0d",
							want.channel_value, channel_value);
						errors++;
					end
					if (tx_byte !== want.tx_byte) begin
						$error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_byte);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic offer_byte(input logic [7:0] b);
		line_q.push_back({ACTION_LINE, b, 16'($urandom), 32'($urandom)});
		queued++;
	endtask

	task automatic offer_value(input logic [15:0] id, input logic [31:0] val);
		line_q.push_back({ACTION_QUEUE, 8'($urandom), id, val});
		queued++;
	endtask

	// payload byte that does not close the frame early
	function automatic logic [7:0] payload_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == END_MARK)
			b = 8'h7F;
		return b;
	endfunction

	task automatic offer_channel_frame(input int npay, input int len);
		offer_byte(8'(len));
		offer_byte(TYPE_CHANNELS);
		repeat (npay) offer_byte(payload_byte());
		offer_byte(END_MARK);
	endtask

	task automatic offer_poll(input int nfill);
		offer_byte(8'(nfill + 1));
		offer_byte(TYPE_POLL);
		repeat (nfill) offer_byte(payload_byte());
		offer_byte(END_MARK);
	endtask

	// Wait until every queued transaction has been sent and every expected result has arrived.
	task automatic settle();
		while (line_q.size() != 0 || in_valid || outbound_q.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	initial begin
		int roll;
		int npay;
		int start;
		logic [31:0] val;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames
		offer_poll(2);                               // poll, nothing pending
		offer_value(16'hFFFF, 32'hFFFF_FFFF);
		offer_value(16'h0000, 32'h0000_0000);        // ignored while pending
		offer_poll(2);                               // reply with all-ones check fold
		offer_value(16'h0000, 32'h0000_0000);
		offer_poll(2);
		offer_channel_frame(2, 3);                   // short frame reads stale bytes
		offer_byte(8'h00); offer_byte(TYPE_CHANNELS); offer_byte(8'hFF);
		offer_byte(END_MARK);                        // three bytes only
		offer_byte(8'h09); offer_byte(TYPE_CHANNELS); offer_byte(8'h00);
		offer_byte(8'hFF); offer_byte(END_MARK);     // length check fails
		offer_byte(8'h03); offer_byte(8'h55); offer_byte(8'h00);
		offer_byte(8'hFF); offer_byte(END_MARK);     // unknown type
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 48; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 48; end
				default: begin send_idle_pct = 30; stall_pct = 30; end
			endcase
			start = queued;
			while (queued - start < PHASE_ITEMS) begin
				roll = $urandom_range(99);
				if (roll < 45) begin
					case ($urandom_range(9))
						0:       npay = $urandom_range(2, 21);
						1:       npay = 30;               // frame fills the store
						default: npay = 22;
					endcase
					offer_channel_frame(npay, ($urandom_range(4) == 0) ?
						$urandom_range(0, npay + 1) : npay + 1);
				end else if (roll < 65) begin
					case ($urandom_range(3))
						0:       val = 32'h0000_0000;
						1:       val = 32'hFFFF_FFFF;
						default: val = $urandom;
					endcase
					offer_value(($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom), val);
					offer_poll($urandom_range(2, 4));
				end else if (roll < 75) begin
					offer_value(16'($urandom), $urandom);
				end else if (roll < 85) begin
					// noise: random bytes, closes included
					repeat ($urandom_range(1, 6)) offer_byte(8'($urandom));
					offer_byte(END_MARK);
				end else if (roll < 92) begin
					// overflow the store, then a tail that starts afresh
					repeat (STORE_DEPTH + $urandom_range(1, 8)) offer_byte(payload_byte());
					offer_byte(END_MARK);
				end else begin
					// bad length or unknown type
					offer_byte(($urandom_range(1) == 0) ? 8'($urandom_range(8, 255)) : 8'h02);
					offer_byte(($urandom_range(1) == 0) ? TYPE_CHANNELS : 8'($urandom));
					repeat ($urandom_range(2, 6)) offer_byte(payload_byte());
					offer_byte(END_MARK);
				end
			end
			settle();
		end

		// back-pressure: receiver holds off while the sender keeps offering frames
		send_idle_pct = 0;
		stall_pct = 0;
		hold_arm = 1'b1;
		repeat (4) offer_channel_frame(22, 23);
		offer_value(16'($urandom), $urandom);
		offer_poll(3);
		settle();

		if (outbound_q.size() != 0) begin
			$error("%0d expected results never arrived", outbound_q.size());
			errors++;
		end
		$display("covered %0d input transactions: %0d channel runs and %0d telemetry replies",
			accepted, channel_runs, replies);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
